// ===== src/rwhp_pkg.sv =====
// Shared types, constants and microcode table of the RIFF/WAVE header parser.
package rwhp_pkg;

    localparam int BYTE_W  = 8;
    localparam int HALF_W  = 16;
    localparam int WORD_W  = 32;
    localparam int SKIP_W  = 33;
    localparam int STAT_W  = 3;
    localparam int LANE_W  = 2;
    localparam int FRAC_W  = 3;

    localparam logic [WORD_W-1:0] MAGIC_RIFF = 32'h4646_4952;
    localparam logic [WORD_W-1:0] MAGIC_WAVE = 32'h4556_4157;
    localparam logic [WORD_W-1:0] MAGIC_FMT  = 32'h2074_6D66;
    localparam logic [WORD_W-1:0] MAGIC_DATA = 32'h6174_6164;
    localparam logic [WORD_W-1:0] FMT_MIN    = 32'd16;

    localparam logic [HALF_W-1:0] FMT_PCM        = 16'h0001;
    localparam logic [HALF_W-1:0] FMT_FLOAT      = 16'h0003;
    localparam logic [HALF_W-1:0] FMT_ALAW       = 16'h0006;
    localparam logic [HALF_W-1:0] FMT_MULAW      = 16'h0007;
    localparam logic [HALF_W-1:0] FMT_EXTENSIBLE = 16'hFFFE;

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_NO_RIFF,
        ST_NO_WAVE,
        ST_NO_FMT,
        ST_BAD_FORMAT,
        ST_ALIGN_MISMATCH,
        ST_RATE_MISMATCH,
        ST_FMT_SHORT
    } status_t;

    // Program counter of the microcode sequencer.
    typedef enum logic [4:0] {
        PH_RIFF,
        PH_RIFFSIZE,
        PH_WAVE,
        PH_FMT,
        PH_FMTSIZE,
        PH_FORMAT,
        PH_CHANNELS,
        PH_RATE,
        PH_BYTERATE,
        PH_ALIGN,
        PH_BITS,
        PH_MUL,
        PH_CHKALIGN,
        PH_CHKRATE,
        PH_FMTREST,
        PH_SKIP,
        PH_CHUNKID,
        PH_CHUNKSIZE,
        PH_DATASIZE,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        D_NONE,
        D_FMTLEFT,
        D_FORMAT,
        D_CHANNELS,
        D_RATE,
        D_BYTERATE,
        D_ALIGN,
        D_BITS
    } dest_t;

    typedef enum logic [1:0] {
        SK_NONE,
        SK_FMT,
        SK_CHUNK
    } skip_src_t;

    typedef enum logic [2:0] {
        T_NONE,
        T_MAGIC,
        T_FMTSIZE,
        T_FORMAT,
        T_ALIGN,
        T_RATE,
        T_LOADNZ,
        T_SKIPZ
    } test_t;

    typedef enum logic [1:0] {
        MG_RIFF,
        MG_WAVE,
        MG_FMT,
        MG_DATA
    } magic_t;

    typedef struct packed {
        logic      byte_step;   // step waits for an input byte
        logic      field_en;    // byte goes into the field accumulator
        logic      len2;        // two-byte field, otherwise four
        logic      skip_en;     // byte is counted off the skip counter
        logic      count_en;    // byte advances the file offset
        dest_t     dest;
        skip_src_t skip_src;
        test_t     test;
        magic_t    magic;
        logic      fail_emit;   // failed test sends an error result
        logic      emit_ok;     // completed step sends the good result
        status_t   fail_status;
        phase_t    next_ph;     // taken when the test passes
        phase_t    alt_ph;      // taken when the test fails without a result
    } ctl_word_t;

    typedef struct packed {
        logic complete;
        logic pass;
        logic emit;
    } dp_flags_t;

    typedef struct packed {
        status_t             status;
        logic [HALF_W-1:0]   audio_format;
        logic [HALF_W-1:0]   channel_count;
        logic [WORD_W-1:0]   sample_rate;
        logic [WORD_W-1:0]   bytes_per_second;
        logic [HALF_W-1:0]   frame_bytes;
        logic [HALF_W-1:0]   sample_bits;
        logic [WORD_W-1:0]   payload_size;
        logic [WORD_W-1:0]   payload_offset;
    } out_item_t;

    function automatic logic [WORD_W-1:0] magic_word(input magic_t m);
        logic [WORD_W-1:0] w;
        unique case (m)
            MG_RIFF: w = MAGIC_RIFF;
            MG_WAVE: w = MAGIC_WAVE;
            MG_FMT:  w = MAGIC_FMT;
            MG_DATA: w = MAGIC_DATA;
            default: w = MAGIC_DATA;
        endcase
        return w;
    endfunction

    function automatic logic format_ok(input logic [HALF_W-1:0] f);
        return (f == FMT_PCM) || (f == FMT_FLOAT) || (f == FMT_ALAW) ||
               (f == FMT_MULAW) || (f == FMT_EXTENSIBLE);
    endfunction

    // Microcode ROM: one control word per step.
    function automatic ctl_word_t ucode(input phase_t ph);
        ctl_word_t w;
        w             = '0;
        w.byte_step   = 1'b1;
        w.field_en    = 1'b1;
        w.count_en    = 1'b1;
        w.dest        = D_NONE;
        w.skip_src    = SK_NONE;
        w.test        = T_NONE;
        w.magic       = MG_RIFF;
        w.fail_status = ST_OK;
        w.next_ph     = PH_DONE;
        w.alt_ph      = PH_DONE;
        unique case (ph)
            PH_RIFF:
            begin
                w.test        = T_MAGIC;
                w.magic       = MG_RIFF;
                w.fail_emit   = 1'b1;
                w.fail_status = ST_NO_RIFF;
                w.next_ph     = PH_RIFFSIZE;
            end
            PH_RIFFSIZE:
            begin
                w.next_ph = PH_WAVE;
            end
            PH_WAVE:
            begin
                w.test        = T_MAGIC;
                w.magic       = MG_WAVE;
                w.fail_emit   = 1'b1;
                w.fail_status = ST_NO_WAVE;
                w.next_ph     = PH_FMT;
            end
            PH_FMT:
            begin
                w.test        = T_MAGIC;
                w.magic       = MG_FMT;
                w.fail_emit   = 1'b1;
                w.fail_status = ST_NO_FMT;
                w.next_ph     = PH_FMTSIZE;
            end
            PH_FMTSIZE:
            begin
                w.dest        = D_FMTLEFT;
                w.test        = T_FMTSIZE;
                w.fail_emit   = 1'b1;
                w.fail_status = ST_FMT_SHORT;
                w.next_ph     = PH_FORMAT;
            end
            PH_FORMAT:
            begin
                w.len2        = 1'b1;
                w.dest        = D_FORMAT;
                w.test        = T_FORMAT;
                w.fail_emit   = 1'b1;
                w.fail_status = ST_BAD_FORMAT;
                w.next_ph     = PH_CHANNELS;
            end
            PH_CHANNELS:
            begin
                w.len2    = 1'b1;
                w.dest    = D_CHANNELS;
                w.next_ph = PH_RATE;
            end
            PH_RATE:
            begin
                w.dest    = D_RATE;
                w.next_ph = PH_BYTERATE;
            end
            PH_BYTERATE:
            begin
                w.dest    = D_BYTERATE;
                w.next_ph = PH_ALIGN;
            end
            PH_ALIGN:
            begin
                w.len2    = 1'b1;
                w.dest    = D_ALIGN;
                w.next_ph = PH_BITS;
            end
            PH_BITS:
            begin
                w.len2    = 1'b1;
                w.dest    = D_BITS;
                w.next_ph = PH_MUL;
            end
            PH_MUL:
            begin
                w.byte_step = 1'b0;
                w.field_en  = 1'b0;
                w.count_en  = 1'b0;
                w.next_ph   = PH_CHKALIGN;
            end
            PH_CHKALIGN:
            begin
                w.byte_step   = 1'b0;
                w.field_en    = 1'b0;
                w.count_en    = 1'b0;
                w.test        = T_ALIGN;
                w.fail_emit   = 1'b1;
                w.fail_status = ST_ALIGN_MISMATCH;
                w.next_ph     = PH_CHKRATE;
            end
            PH_CHKRATE:
            begin
                w.byte_step   = 1'b0;
                w.field_en    = 1'b0;
                w.count_en    = 1'b0;
                w.test        = T_RATE;
                w.fail_emit   = 1'b1;
                w.fail_status = ST_RATE_MISMATCH;
                w.next_ph     = PH_FMTREST;
            end
            PH_FMTREST:
            begin
                w.byte_step = 1'b0;
                w.field_en  = 1'b0;
                w.count_en  = 1'b0;
                w.skip_src  = SK_FMT;
                w.test      = T_LOADNZ;
                w.next_ph   = PH_SKIP;
                w.alt_ph    = PH_CHUNKID;
            end
            PH_SKIP:
            begin
                w.field_en = 1'b0;
                w.skip_en  = 1'b1;
                w.test     = T_SKIPZ;
                w.next_ph  = PH_CHUNKID;
                w.alt_ph   = PH_SKIP;
            end
            PH_CHUNKID:
            begin
                w.test    = T_MAGIC;
                w.magic   = MG_DATA;
                w.next_ph = PH_DATASIZE;
                w.alt_ph  = PH_CHUNKSIZE;
            end
            PH_CHUNKSIZE:
            begin
                w.skip_src = SK_CHUNK;
                w.test     = T_LOADNZ;
                w.next_ph  = PH_SKIP;
                w.alt_ph   = PH_CHUNKID;
            end
            PH_DATASIZE:
            begin
                w.emit_ok = 1'b1;
                w.next_ph = PH_DONE;
            end
            default:
            begin
                w.field_en = 1'b0;
                w.count_en = 1'b0;
                w.next_ph  = PH_DONE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== src/rwhp_in_if.sv =====
// Input byte channel of the RIFF/WAVE header parser.
interface rwhp_in_if;
    logic                        valid;
    logic                        ready;
    logic [rwhp_pkg::BYTE_W-1:0] byte_value;
    logic                        restart;

    modport source (output valid, output byte_value, output restart, input ready);
    modport sink   (input valid, input byte_value, input restart, output ready);
endinterface

// ===== src/rwhp_out_if.sv =====
// Result channel of the RIFF/WAVE header parser.
interface rwhp_out_if;
    logic                        valid;
    logic                        ready;
    logic [rwhp_pkg::STAT_W-1:0] status;
    logic [rwhp_pkg::HALF_W-1:0] audio_format;
    logic [rwhp_pkg::HALF_W-1:0] channel_count;
    logic [rwhp_pkg::WORD_W-1:0] sample_rate;
    logic [rwhp_pkg::WORD_W-1:0] bytes_per_second;
    logic [rwhp_pkg::HALF_W-1:0] frame_bytes;
    logic [rwhp_pkg::HALF_W-1:0] sample_bits;
    logic [rwhp_pkg::WORD_W-1:0] payload_size;
    logic [rwhp_pkg::WORD_W-1:0] payload_offset;

    modport source (output valid, output status, output audio_format,
                    output channel_count, output sample_rate, output bytes_per_second,
                    output frame_bytes, output sample_bits, output payload_size,
                    output payload_offset, input ready);
    modport sink   (input valid, input status, input audio_format,
                    input channel_count, input sample_rate, input bytes_per_second,
                    input frame_bytes, input sample_bits, input payload_size,
                    input payload_offset, output ready);
endinterface

// ===== src/rwhp_useq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
module rwhp_useq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                exec,
    input  rwhp_pkg::dp_flags_t flags,
    output rwhp_pkg::ctl_word_t ctl
);

    rwhp_pkg::phase_t pc_reg;
    rwhp_pkg::phase_t pc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= rwhp_pkg::PH_RIFF;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // Next step: restart wins, then branch on the datapath test.
    always_comb
    begin
        pc_next = pc_reg;
        if (clear)
        begin
            pc_next = rwhp_pkg::PH_RIFF;
        end
        else if (exec && flags.complete)
        begin
            if (flags.pass)
            begin
                pc_next = ctl.next_ph;
            end
            else if (ctl.fail_emit)
            begin
                pc_next = rwhp_pkg::PH_DONE;
            end
            else
            begin
                pc_next = ctl.alt_ph;
            end
        end
    end

    always_comb
    begin
        ctl = rwhp_pkg::ucode(pc_reg);
    end

    a_restart_to_riff: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (pc_reg == rwhp_pkg::PH_RIFF))
        else $error("restart did not return the sequencer to the RIFF step");

    a_mul_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == rwhp_pkg::PH_MUL) |=> (pc_reg == rwhp_pkg::PH_CHKALIGN))
        else $error("multiply step did not advance to the alignment check");

endmodule

// ===== src/rwhp_dp.sv =====
// Datapath: field accumulator, fmt registers, multiplier pipe, skip and offset counters.
module rwhp_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        exec,
    input  rwhp_pkg::ctl_word_t         ctl,
    input  logic [rwhp_pkg::BYTE_W-1:0] byte_value,
    output rwhp_pkg::dp_flags_t         flags,
    output rwhp_pkg::out_item_t         result
);

    logic [rwhp_pkg::LANE_W-1:0] lane_reg, lane_next;
    logic [rwhp_pkg::WORD_W-1:0] field_reg, field_next;
    logic [rwhp_pkg::WORD_W-1:0] fmt_left_reg, fmt_left_next;
    logic [rwhp_pkg::SKIP_W-1:0] skip_reg, skip_next;
    logic [rwhp_pkg::WORD_W-1:0] position_reg, position_next;
    logic [rwhp_pkg::HALF_W-1:0] format_reg, format_next;
    logic [rwhp_pkg::HALF_W-1:0] channels_reg, channels_next;
    logic [rwhp_pkg::WORD_W-1:0] rate_reg, rate_next;
    logic [rwhp_pkg::WORD_W-1:0] byterate_reg, byterate_next;
    logic [rwhp_pkg::HALF_W-1:0] align_reg, align_next;
    logic [rwhp_pkg::HALF_W-1:0] bits_reg, bits_next;

    logic [rwhp_pkg::WORD_W-1:0] prod_cb_reg;
    logic [rwhp_pkg::WORD_W-1:0] prod_rc_reg;
    logic [rwhp_pkg::WORD_W-1:0] prod_rcb_reg;
    logic [47:0]                 wide_rc;
    logic [47:0]                 wide_rcb;

    logic [rwhp_pkg::WORD_W-1:0] acc_base;
    logic [rwhp_pkg::WORD_W-1:0] acc_cur;
    logic                        field_done;
    logic                        complete;
    logic                        pass;
    logic [rwhp_pkg::SKIP_W-1:0] skip_dec;
    logic [rwhp_pkg::SKIP_W-1:0] skip_load;
    logic                        load_en;

    // Little-endian gather: byte lane picks the slot.
    always_comb
    begin
        acc_base   = (lane_reg == '0) ? '0 : field_reg;
        acc_cur    = acc_base |
                     ({{(rwhp_pkg::WORD_W-rwhp_pkg::BYTE_W){1'b0}}, byte_value}
                      << {lane_reg, 3'b000});
        field_done = ctl.len2 ? (lane_reg == 2'd1) : (lane_reg == 2'd3);
        complete   = !ctl.field_en || field_done;
        load_en    = exec && complete && ctl.field_en;
        skip_dec   = (skip_reg != '0) ? (skip_reg - 33'd1) : skip_reg;
        case (ctl.skip_src)
            rwhp_pkg::SK_FMT:   skip_load = {1'b0, fmt_left_reg - rwhp_pkg::FMT_MIN};
            rwhp_pkg::SK_CHUNK: skip_load = {1'b0, acc_cur} + {32'd0, acc_cur[0]};
            default:            skip_load = '0;
        endcase
    end

    always_comb
    begin
        unique case (ctl.test)
            rwhp_pkg::T_NONE:    pass = 1'b1;
            rwhp_pkg::T_MAGIC:   pass = (acc_cur == rwhp_pkg::magic_word(ctl.magic));
            rwhp_pkg::T_FMTSIZE: pass = (acc_cur >= rwhp_pkg::FMT_MIN);
            rwhp_pkg::T_FORMAT:  pass = rwhp_pkg::format_ok(acc_cur[rwhp_pkg::HALF_W-1:0]);
            rwhp_pkg::T_ALIGN:   pass = ({16'd0, align_reg} ==
                                         {3'd0, prod_cb_reg[rwhp_pkg::WORD_W-1:rwhp_pkg::FRAC_W]});
            rwhp_pkg::T_RATE:    pass = (byterate_reg ==
                                         {3'd0, prod_rcb_reg[rwhp_pkg::WORD_W-1:rwhp_pkg::FRAC_W]});
            rwhp_pkg::T_LOADNZ:  pass = (skip_load != '0);
            rwhp_pkg::T_SKIPZ:   pass = (skip_dec == '0);
            default:             pass = 1'b1;
        endcase
        flags.complete = complete;
        flags.pass     = pass;
        flags.emit     = complete && (ctl.emit_ok || (!pass && ctl.fail_emit));
    end

    always_comb
    begin
        lane_next     = lane_reg;
        field_next    = field_reg;
        fmt_left_next = fmt_left_reg;
        skip_next     = skip_reg;
        position_next = position_reg;
        format_next   = format_reg;
        channels_next = channels_reg;
        rate_next     = rate_reg;
        byterate_next = byterate_reg;
        align_next    = align_reg;
        bits_next     = bits_reg;
        if (exec && ctl.count_en && (position_reg != '1))
        begin
            position_next = position_reg + 32'd1;
        end
        if (exec && ctl.field_en)
        begin
            field_next = acc_cur;
            lane_next  = field_done ? '0 : lane_reg + 2'd1;
        end
        if (load_en)
        begin
            case (ctl.dest)
                rwhp_pkg::D_FMTLEFT:  fmt_left_next = acc_cur;
                rwhp_pkg::D_FORMAT:   format_next   = acc_cur[rwhp_pkg::HALF_W-1:0];
                rwhp_pkg::D_CHANNELS: channels_next = acc_cur[rwhp_pkg::HALF_W-1:0];
                rwhp_pkg::D_RATE:     rate_next     = acc_cur;
                rwhp_pkg::D_BYTERATE: byterate_next = acc_cur;
                rwhp_pkg::D_ALIGN:    align_next    = acc_cur[rwhp_pkg::HALF_W-1:0];
                rwhp_pkg::D_BITS:     bits_next     = acc_cur[rwhp_pkg::HALF_W-1:0];
                default:              field_next    = field_next;
            endcase
        end
        if (exec && ctl.skip_en)
        begin
            skip_next = skip_dec;
        end
        else if (exec && complete && (ctl.skip_src != rwhp_pkg::SK_NONE))
        begin
            skip_next = skip_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg     <= '0;
            field_reg    <= '0;
            fmt_left_reg <= '0;
            skip_reg     <= '0;
            position_reg <= '0;
            format_reg   <= '0;
            channels_reg <= '0;
            rate_reg     <= '0;
            byterate_reg <= '0;
            align_reg    <= '0;
            bits_reg     <= '0;
        end
        else if (clear)
        begin
            lane_reg     <= '0;
            field_reg    <= '0;
            fmt_left_reg <= '0;
            skip_reg     <= '0;
            position_reg <= '0;
            format_reg   <= '0;
            channels_reg <= '0;
            rate_reg     <= '0;
            byterate_reg <= '0;
            align_reg    <= '0;
            bits_reg     <= '0;
        end
        else
        begin
            lane_reg     <= lane_next;
            field_reg    <= field_next;
            fmt_left_reg <= fmt_left_next;
            skip_reg     <= skip_next;
            position_reg <= position_next;
            format_reg   <= format_next;
            channels_reg <= channels_next;
            rate_reg     <= rate_next;
            byterate_reg <= byterate_next;
            align_reg    <= align_next;
            bits_reg     <= bits_next;
        end
    end

    // Free-running multiplier pipe, products wrap to 32 bits.
    always_comb
    begin
        wide_rc  = rate_reg * channels_reg;
        wide_rcb = prod_rc_reg * bits_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_cb_reg  <= channels_reg * bits_reg;
        prod_rc_reg  <= wide_rc[rwhp_pkg::WORD_W-1:0];
        prod_rcb_reg <= wide_rcb[rwhp_pkg::WORD_W-1:0];
    end

    always_comb
    begin
        result.status           = ctl.emit_ok ? rwhp_pkg::ST_OK : ctl.fail_status;
        result.audio_format     = format_next;
        result.channel_count    = channels_next;
        result.sample_rate      = rate_next;
        result.bytes_per_second = byterate_next;
        result.frame_bytes      = align_next;
        result.sample_bits      = bits_next;
        result.payload_size     = ctl.emit_ok ? acc_cur : '0;
        result.payload_offset   = ctl.emit_ok ? position_next : '0;
    end

    a_offset_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !clear |=> (position_reg >= $past(position_reg)))
        else $error("file offset went backward without a restart");

endmodule

// ===== src/riff_wave_header_parser_core.sv =====
// Top level of the RIFF/WAVE header parser: handshakes, byte holding register, result register.
// Flow: each beat is taken into the byte register and then consumed by a microcode step;
//   the bits-per-sample byte is followed by internal steps (multiplier pipe, the two
//   consistency checks and the fmt skip load) before the next byte is taken.
// Output: a step that sends a result, good or error, loads the result register once it is free.
// Reset: rst_n clears the sequencer to the RIFF step, drops any held byte and empties the
//   result register; a beat with restart set clears the parse state before it is consumed.
module riff_wave_header_parser_core (
    input  logic       clk,
    input  logic       rst_n,
    rwhp_in_if.sink    in_ch,
    rwhp_out_if.source out_ch
);

    rwhp_pkg::ctl_word_t ctl;
    rwhp_pkg::dp_flags_t flags;
    rwhp_pkg::out_item_t result;

    logic [rwhp_pkg::BYTE_W-1:0] byte_reg;
    logic                        pend_reg, pend_next;
    logic                        out_valid_reg, out_valid_next;
    rwhp_pkg::out_item_t         out_item_reg;

    logic accept;
    logic clear;
    logic out_free;
    logic exec;
    logic emit_fire;

    // Take a beat only at a byte step with no byte held.
    always_comb
    begin
        in_ch.ready = !pend_reg && ctl.byte_step;
        accept      = in_ch.valid && in_ch.ready;
        clear       = accept && in_ch.restart;
        out_free    = !out_valid_reg || out_ch.ready;
        // Hold a step that sends a result until the result register frees up.
        exec        = (ctl.byte_step ? pend_reg : 1'b1) && !(flags.emit && !out_free);
        emit_fire   = exec && flags.emit;
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (exec && ctl.byte_step)
        begin
            pend_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_ch.byte_value;
        end
        if (emit_fire)
        begin
            out_item_reg <= result;
        end
    end

    rwhp_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (clear),
        .exec  (exec),
        .flags (flags),
        .ctl   (ctl)
    );

    rwhp_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (clear),
        .exec       (exec),
        .ctl        (ctl),
        .byte_value (byte_reg),
        .flags      (flags),
        .result     (result)
    );

    // Drive the result channel from the result register.
    always_comb
    begin
        out_ch.valid            = out_valid_reg;
        out_ch.status           = out_item_reg.status;
        out_ch.audio_format     = out_item_reg.audio_format;
        out_ch.channel_count    = out_item_reg.channel_count;
        out_ch.sample_rate      = out_item_reg.sample_rate;
        out_ch.bytes_per_second = out_item_reg.bytes_per_second;
        out_ch.frame_bytes      = out_item_reg.frame_bytes;
        out_ch.sample_bits      = out_item_reg.sample_bits;
        out_ch.payload_size     = out_item_reg.payload_size;
        out_ch.payload_offset   = out_item_reg.payload_offset;
    end

    a_no_accept_while_held: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !in_ch.ready)
        else $error("input ready while a byte is still held");

    a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg ##1 out_valid_reg) |-> $past(emit_fire))
        else $error("result register filled without a sending step");

endmodule
